>>> hdl/hts_pkg.sv
// ----------------------------------------------------------------------------
// hts_pkg - shared definitions for the Horspool text search block
// Holds character and register widths, register index codes, the
// configuration bundle and helpers for pattern decoding.
// ----------------------------------------------------------------------------
package hts_pkg;

  localparam int unsigned CHAR_BITS     = 7;
  localparam int unsigned LENGTH_BITS   = 5;
  localparam int unsigned CFG_DATA_BITS = 64;
  localparam int unsigned CFG_IDX_BITS  = 2;
  localparam int unsigned PATTERN_BYTES = 16;
  localparam int unsigned PATTERN_BITS  = PATTERN_BYTES * 8;

  // Defaults for the top-level parameters.
  localparam int unsigned MAX_PATTERN_DEFAULT   = 16;
  localparam int unsigned POSITION_BITS_DEFAULT = 48;
  localparam int unsigned QUEUE_DEPTH_DEFAULT   = 2;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_BITS-1:0] REG_PATTERN_LENGTH = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_PATTERN_LOW    = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_PATTERN_HIGH   = 2'd2;

  typedef struct packed {
    logic [LENGTH_BITS-1:0]  pattern_length;
    logic [PATTERN_BITS-1:0] pattern;
  } hts_cfg_t;

  // Working pattern length: zero acts as one, anything above the maximum
  // acts as the maximum.
  function automatic int unsigned eff_len(input logic [LENGTH_BITS-1:0] len,
                                          input int unsigned max_pat);
    int unsigned result;
    result = int'(len);
    if (len == '0) begin
      result = 1;
    end else if (int'(len) > max_pat) begin
      result = max_pat;
    end
    return result;
  endfunction

  // Pattern byte at a given place; places beyond the registers read as zero.
  function automatic logic [7:0] pat_byte(input logic [PATTERN_BITS-1:0] pat,
                                          input int unsigned idx);
    logic [7:0] result;
    result = 8'd0;
    if (idx < PATTERN_BYTES) begin
      result = pat[idx*8 +: 8];
    end
    return result;
  endfunction

endpackage

>>> hdl/horspool_text_search_top.sv
// ----------------------------------------------------------------------------
// horspool_text_search_top - streaming Boyer-Moore-Horspool text search
// Searches a stream of 7-bit characters for a configured pattern and reports
// every compared text position of each right-to-left comparison.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake              Payload
//  --------  ---------  ---------------------  ------------------------------
//  config    in         cfg_write              cfg_index, cfg_data
//  text      in         text_valid/text_stall  text_char, end_of_text
//  result    out        result_valid/stall     compared_position, last_of_run
//
// A text request is taken whenever the job queue has room; the front part
// updates the window and, when the window is aligned, queues a snapshot for
// comparison. The back part compares one character per cycle while the
// result side does not stall; an aligned window costs one to pattern_length
// comparisons there, and that comparison unit sets the sustained rate: one
// request per cycle while the queue has room, else one per comparison run.
// Reset is synchronous and active high; it loads a pattern length of one,
// an all-zero pattern and an empty window, and needs no clearing pass.
// A stall on the result side holds the registered result and, once the queue
// fills, raises text_stall; text_stall never depends on text_valid.
// Configuration writes are meant for idle periods and restart the stream.
// ----------------------------------------------------------------------------
module horspool_text_search_top import hts_pkg::*; #(
  parameter int unsigned MAX_PATTERN   = MAX_PATTERN_DEFAULT,
  parameter int unsigned POSITION_BITS = POSITION_BITS_DEFAULT,
  parameter int unsigned QUEUE_DEPTH   = QUEUE_DEPTH_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_write,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  input  logic                     text_valid,
  output logic                     text_stall,
  input  logic [CHAR_BITS-1:0]     text_char,
  input  logic                     end_of_text,
  output logic                     result_valid,
  input  logic                     result_stall,
  output logic [POSITION_BITS-1:0] compared_position,
  output logic                     last_of_run
);

  // One job is a window snapshot together with the position of its oldest
  // character.
  localparam int unsigned JOB_BITS = MAX_PATTERN * CHAR_BITS + POSITION_BITS;

  hts_cfg_t            cfg;
  logic                job_push;
  logic [JOB_BITS-1:0] job_push_data;
  logic                job_full;
  logic                job_pop;
  logic                job_valid;
  logic [JOB_BITS-1:0] job_head;

  // Front part: configuration registers, window and alignment tracking.
  hts_front #(
    .MAX_PATTERN   (MAX_PATTERN),
    .POSITION_BITS (POSITION_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .text_valid  (text_valid),
    .text_stall  (text_stall),
    .text_char   (text_char),
    .end_of_text (end_of_text),
    .cfg         (cfg),
    .job_push    (job_push),
    .job_data    (job_push_data),
    .job_full    (job_full)
  );

  // The queue lets the front keep taking characters while a comparison run
  // is still draining through the result port.
  hts_queue #(
    .WIDTH (JOB_BITS),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (job_push),
    .push_data (job_push_data),
    .full      (job_full),
    .pop       (job_pop),
    .nonempty  (job_valid),
    .head_data (job_head)
  );

  // Back part: compares from the rightmost character leftwards and stops at
  // the first mismatch or after the full pattern.
  hts_back #(
    .MAX_PATTERN   (MAX_PATTERN),
    .POSITION_BITS (POSITION_BITS)
  ) u_back (
    .clk               (clk),
    .rst               (rst),
    .cfg               (cfg),
    .job_valid         (job_valid),
    .job_data          (job_head),
    .job_pop           (job_pop),
    .result_valid      (result_valid),
    .result_stall      (result_stall),
    .compared_position (compared_position),
    .last_of_run       (last_of_run)
  );

endmodule

>>> hdl/hts_queue.sv
// ----------------------------------------------------------------------------
// hts_queue - short job queue between the front and back parts
// A small circular buffer of comparison jobs with registered occupancy.
// ----------------------------------------------------------------------------
module hts_queue import hts_pkg::*; #(
  parameter int unsigned WIDTH = 160,
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             nonempty,
  output logic [WIDTH-1:0] head_data
);

  localparam int unsigned PTR_BITS   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned COUNT_BITS = $clog2(DEPTH + 1);
  localparam logic [PTR_BITS-1:0]   PTR_LAST  = PTR_BITS'(DEPTH - 1);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = COUNT_BITS'(DEPTH);

  logic [WIDTH-1:0]      entries [DEPTH];
  logic [PTR_BITS-1:0]   rd_ptr;
  logic [PTR_BITS-1:0]   wr_ptr;
  logic [COUNT_BITS-1:0] count;

  assign full      = (count == COUNT_MAX);
  assign nonempty  = (count != '0);
  assign head_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PTR_BITS'(1);
      end
      if (push && !pop) begin
        count <= count + COUNT_BITS'(1);
      end else if (pop && !push) begin
        count <= count - COUNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("job pushed into a full queue");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> nonempty)
    else $error("job popped from an empty queue");

endmodule

>>> hdl/hts_front.sv
// ----------------------------------------------------------------------------
// hts_front - configuration, text window and alignment tracking
// Accepts text characters, keeps the window and position, decides when the
// window is aligned and hands a snapshot to the comparison queue.
// ----------------------------------------------------------------------------
module hts_front import hts_pkg::*; #(
  parameter int unsigned MAX_PATTERN   = MAX_PATTERN_DEFAULT,
  parameter int unsigned POSITION_BITS = POSITION_BITS_DEFAULT,
  localparam int unsigned JOB_BITS     = MAX_PATTERN * CHAR_BITS + POSITION_BITS
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_write,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  input  logic                     text_valid,
  output logic                     text_stall,
  input  logic [CHAR_BITS-1:0]     text_char,
  input  logic                     end_of_text,
  output hts_cfg_t                 cfg,
  output logic                     job_push,
  output logic [JOB_BITS-1:0]      job_data,
  input  logic                     job_full
);

  localparam int unsigned LEN_BITS = $clog2(MAX_PATTERN + 1);
  localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

  logic [LENGTH_BITS-1:0]   pattern_length;
  logic [CFG_DATA_BITS-1:0] pattern_chars_low;
  logic [CFG_DATA_BITS-1:0] pattern_chars_high;

  logic [CHAR_BITS-1:0]     window [MAX_PATTERN];
  logic [CHAR_BITS-1:0]     window_next [MAX_PATTERN];
  logic [LEN_BITS-1:0]      fill;
  logic [LEN_BITS-1:0]      fill_next;
  logic [POSITION_BITS-1:0] position;
  logic [POSITION_BITS-1:0] position_next;
  logic [LEN_BITS-1:0]      chars_needed;
  logic [LEN_BITS-1:0]      chars_needed_next;

  logic [LEN_BITS-1:0]      m;
  logic [7:0]               pat_bytes [MAX_PATTERN];
  logic [LEN_BITS-1:0]      shift;
  logic                     accept;
  logic                     full_before;
  logic [LEN_BITS-1:0]      fill_after;
  logic [POSITION_BITS-1:0] position_after;
  logic [LEN_BITS-1:0]      needed_dec;
  logic                     fire;
  logic [LENGTH_BITS-1:0]   cfg_len_next;
  logic                     cfg_restart;

  assign cfg.pattern_length = pattern_length;
  assign cfg.pattern        = {pattern_chars_high, pattern_chars_low};

  assign m          = LEN_BITS'(eff_len(pattern_length, MAX_PATTERN));
  assign text_stall = job_full;
  assign accept     = text_valid && !text_stall;

  for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_window
    assign pat_bytes[i] = pat_byte(cfg.pattern, i);
    if (i < MAX_PATTERN - 1) begin : g_mid
      always_comb begin
        if (LEN_BITS'(i + 1) < m) begin
          window_next[i] = window[i + 1];
        end else if (LEN_BITS'(i + 1) == m) begin
          window_next[i] = text_char;
        end else begin
          window_next[i] = window[i];
        end
      end
    end else begin : g_top
      assign window_next[i] = (LEN_BITS'(i + 1) == m) ? text_char : window[i];
    end
    assign job_data[i*CHAR_BITS +: CHAR_BITS] = window_next[i];
  end

  // Horspool shift for the character that now closes the window: the
  // rightmost occurrence among the first m-1 pattern places wins.
  always_comb begin
    shift = m;
    for (int j = 0; j < MAX_PATTERN - 1; j++) begin
      if ((LEN_BITS'(j + 1) < m) && (pat_bytes[j] == {1'b0, text_char})) begin
        shift = m - LEN_BITS'(j + 1);
      end
    end
  end

  always_comb begin
    full_before    = (fill >= m);
    fill_after     = full_before ? fill : fill + LEN_BITS'(1);
    position_after = position;
    if (full_before && (position != POS_MAX)) begin
      position_after = position + POSITION_BITS'(1);
    end
    needed_dec = (chars_needed != '0) ? chars_needed - LEN_BITS'(1) : '0;
    fire       = (needed_dec == '0) && (fill_after >= m);

    fill_next         = fill_after;
    position_next     = position_after;
    chars_needed_next = fire ? shift : needed_dec;
    if (end_of_text) begin
      fill_next         = '0;
      position_next     = POSITION_BITS'(1);
      chars_needed_next = m;
    end
  end

  assign job_push = accept && fire;
  assign job_data[JOB_BITS-1 -: POSITION_BITS] = position_after;

  always_comb begin
    cfg_restart  = 1'b0;
    cfg_len_next = pattern_length;
    case (cfg_index)
      REG_PATTERN_LENGTH: begin
        cfg_restart  = 1'b1;
        cfg_len_next = cfg_data[LENGTH_BITS-1:0];
      end
      REG_PATTERN_LOW:  cfg_restart = 1'b1;
      REG_PATTERN_HIGH: cfg_restart = 1'b1;
      default:          cfg_restart = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length     <= LENGTH_BITS'(1);
      pattern_chars_low  <= '0;
      pattern_chars_high <= '0;
      fill               <= '0;
      position           <= POSITION_BITS'(1);
      chars_needed       <= LEN_BITS'(1);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_PATTERN_LENGTH: pattern_length     <= cfg_data[LENGTH_BITS-1:0];
        REG_PATTERN_LOW:    pattern_chars_low  <= cfg_data;
        REG_PATTERN_HIGH:   pattern_chars_high <= cfg_data;
        default:            pattern_length     <= pattern_length;
      endcase
      if (cfg_restart) begin
        fill         <= '0;
        position     <= POSITION_BITS'(1);
        chars_needed <= LEN_BITS'(eff_len(cfg_len_next, MAX_PATTERN));
      end
    end else if (accept) begin
      fill         <= fill_next;
      position     <= position_next;
      chars_needed <= chars_needed_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      window <= window_next;
    end
  end

endmodule

>>> hdl/hts_back.sv
// ----------------------------------------------------------------------------
// hts_back - right-to-left comparison engine
// Takes one window snapshot at a time and emits one compared position per
// cycle unless result_stall holds it, through a registered output stage.
// ----------------------------------------------------------------------------
module hts_back import hts_pkg::*; #(
  parameter int unsigned MAX_PATTERN   = MAX_PATTERN_DEFAULT,
  parameter int unsigned POSITION_BITS = POSITION_BITS_DEFAULT,
  localparam int unsigned JOB_BITS     = MAX_PATTERN * CHAR_BITS + POSITION_BITS
) (
  input  logic                     clk,
  input  logic                     rst,
  input  hts_cfg_t                 cfg,
  input  logic                     job_valid,
  input  logic [JOB_BITS-1:0]      job_data,
  output logic                     job_pop,
  output logic                     result_valid,
  input  logic                     result_stall,
  output logic [POSITION_BITS-1:0] compared_position,
  output logic                     last_of_run
);

  localparam int unsigned LEN_BITS = $clog2(MAX_PATTERN + 1);
  localparam int unsigned IDX_BITS = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

  logic                     busy;
  logic [IDX_BITS-1:0]      j;
  logic [CHAR_BITS-1:0]     job_window [MAX_PATTERN];
  logic [POSITION_BITS-1:0] job_start;

  logic [LEN_BITS-1:0]      m;
  logic [IDX_BITS-1:0]      m_last;
  logic [7:0]               pat_bytes [MAX_PATTERN];
  logic                     can_emit;
  logic                     emit;
  logic                     match;
  logic                     done;
  logic [POSITION_BITS:0]   pos_sum;
  logic [POSITION_BITS-1:0] pos_sat;

  for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_pat
    assign pat_bytes[i] = pat_byte(cfg.pattern, i);
  end

  assign m        = LEN_BITS'(eff_len(cfg.pattern_length, MAX_PATTERN));
  assign m_last   = IDX_BITS'(m - LEN_BITS'(1));
  assign can_emit = !result_valid || !result_stall;
  assign emit     = busy && can_emit;
  assign match    = ({1'b0, job_window[j]} == pat_bytes[j]);
  assign done     = emit && (!match || (j == '0));
  assign job_pop  = job_valid && (!busy || done);
  assign pos_sum  = {1'b0, job_start} + (POSITION_BITS + 1)'(j);
  assign pos_sat  = pos_sum[POSITION_BITS] ? POS_MAX : pos_sum[POSITION_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy         <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (job_pop) begin
        busy <= 1'b1;
      end else if (done) begin
        busy <= 1'b0;
      end
      if (emit) begin
        result_valid <= 1'b1;
      end else if (can_emit) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      compared_position <= pos_sat;
      last_of_run       <= done;
    end
    if (job_pop) begin
      j         <= m_last;
      job_start <= job_data[JOB_BITS-1 -: POSITION_BITS];
      for (int i = 0; i < MAX_PATTERN; i++) begin
        job_window[i] <= job_data[i*CHAR_BITS +: CHAR_BITS];
      end
    end else if (emit) begin
      j <= j - IDX_BITS'(1);
    end
  end

  a_index_in_window: assert property (@(posedge clk) disable iff (rst)
    busy |-> (LEN_BITS'(j) < m))
    else $error("comparison index outside the pattern");

  a_run_steps_down: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_stall && !last_of_run && (compared_position != POS_MAX))
    |=> (result_valid && (compared_position == $past(compared_position) - POSITION_BITS'(1))))
    else $error("run did not continue at the next lower position");

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - self-checking testbench for the Horspool text search block
// Drives text requests and configuration writes into the block, predicts
// every compared position with a cycle-free model of the search, and checks
// each result request in order against that prediction. A short table of
// directed requests comes first, followed by random search phases.
// ----------------------------------------------------------------------------
module tb;
  import hts_pkg::*;

  localparam int unsigned PAT_MAX      = MAX_PATTERN_DEFAULT;
  localparam int unsigned POS_W        = POSITION_BITS_DEFAULT;
  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};
  localparam int RANDOM_ITEMS          = 385;
  // Cycles to let pass once nothing is expected: covers a full 16-character
  // comparison run still in the job queue plus the registered result.
  localparam int SETTLE_CYCLES         = 60;
  localparam int CYCLE_LIMIT           = 600000;

  // One predicted comparison result.
  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic             last;
  } compare_t;

  // One line of the directed table: either a register write or a text
  // request. Where want_n is not negative, the number of comparisons and the
  // position of the final one are typed in by hand.
  typedef struct packed {
    logic                     is_cfg;
    logic [CFG_IDX_BITS-1:0]  reg_idx;
    logic [CFG_DATA_BITS-1:0] data;
    logic [CHAR_BITS-1:0]     ch;
    logic                     eot;
    int                       want_n;
    logic [POS_W-1:0]         want_last;
  } step_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     cfg_write = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;
  logic                     text_valid = 1'b0;
  logic                     text_stall;
  logic [CHAR_BITS-1:0]     text_char = '0;
  logic                     end_of_text = 1'b0;
  logic                     result_valid;
  logic                     result_stall = 1'b0;
  logic [POS_W-1:0]         compared_position;
  logic                     last_of_run;

  horspool_text_search_top dut (
    .clk               (clk),
    .rst               (rst),
    .cfg_write         (cfg_write),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .text_valid        (text_valid),
    .text_stall        (text_stall),
    .text_char         (text_char),
    .end_of_text       (end_of_text),
    .result_valid      (result_valid),
    .result_stall      (result_stall),
    .compared_position (compared_position),
    .last_of_run       (last_of_run)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Search model. It keeps its own copy of the registers, the window, the
  // bad-character shift table and the stream position, and turns every
  // accepted text request into the comparison results the block must emit.
  // --------------------------------------------------------------------------
  logic [LENGTH_BITS-1:0]   len_reg;
  logic [CFG_DATA_BITS-1:0] pat_lo;
  logic [CFG_DATA_BITS-1:0] pat_hi;
  logic [CHAR_BITS-1:0]     win_chars [0:PAT_MAX-1];
  logic [LENGTH_BITS-1:0]   skip_by [0:127];
  int unsigned              win_fill;
  logic [POS_W-1:0]         win_base;
  int unsigned              chars_to_go;
  logic [POS_W-1:0]         last_predicted_pos;

  compare_t pending_compares [$];

  int error_count   = 0;
  int results_seen  = 0;
  int items_sent    = 0;
  int settings_used = 0;
  int burst_left    = 0;
  int gap_max       = 4;
  int cycle_count   = 0;

  // A length of zero behaves as one; anything above the maximum is clipped.
  function automatic int unsigned active_len();
    if (len_reg == '0) begin
      return 1;
    end
    if (int'(len_reg) > PAT_MAX) begin
      return PAT_MAX;
    end
    return int'(len_reg);
  endfunction

  // Pattern byte j, taken from the low register for 0..7 and the high one
  // for 8..15.
  function automatic logic [7:0] pattern_byte(input int unsigned j);
    if (j < 8) begin
      return pat_lo[8*j +: 8];
    end
    if (j < 16) begin
      return pat_hi[8*(j-8) +: 8];
    end
    return 8'd0;
  endfunction

  function automatic logic [CHAR_BITS-1:0] pattern_char(input int unsigned j);
    logic [7:0] b;
    b = pattern_byte(j);
    return b[CHAR_BITS-1:0];
  endfunction

  function automatic logic [POS_W-1:0] pos_plus(input logic [POS_W-1:0] a,
                                                input int unsigned b);
    logic [POS_W:0] s;
    s = {1'b0, a} + (POS_W+1)'(b);
    if (s > {1'b0, POS_MAX}) begin
      s = {1'b0, POS_MAX};
    end
    return s[POS_W-1:0];
  endfunction

  // Rebuild the shift table from the pattern and empty the window. Bytes
  // above 127 can never occur in the text, so they leave the table alone.
  function automatic void restart_search();
    int unsigned m;
    logic [7:0] b;
    m = active_len();
    for (int c = 0; c < 128; c++) begin
      skip_by[c] = LENGTH_BITS'(m);
    end
    for (int unsigned j = 0; j + 1 < m; j++) begin
      b = pattern_byte(j);
      if (b < 8'd128) begin
        skip_by[b[6:0]] = LENGTH_BITS'(m - 1 - j);
      end
    end
    win_fill    = 0;
    win_base    = POS_W'(1);
    chars_to_go = m;
  endfunction

  // An index that names no register changes nothing at all.
  function automatic void apply_write(input logic [CFG_IDX_BITS-1:0] idx,
                                      input logic [CFG_DATA_BITS-1:0] val);
    case (idx)
      REG_PATTERN_LENGTH: len_reg = val[LENGTH_BITS-1:0];
      REG_PATTERN_LOW:    pat_lo = val;
      REG_PATTERN_HIGH:   pat_hi = val;
      default:            return;
    endcase
    restart_search();
  endfunction

  // Shift one character into the window and, if an alignment is due,
  // compare right to left until the first mismatch or the pattern start.
  // Returns the number of comparison results queued.
  function automatic int predict_compares(input logic [CHAR_BITS-1:0] ch,
                                          input logic eot);
    int unsigned m;
    int unsigned j;
    int n;
    logic stop;
    compare_t c;
    m = active_len();
    n = 0;
    if (win_fill >= m) begin
      win_base = pos_plus(win_base, 1);
    end else begin
      win_fill++;
    end
    for (j = 0; j + 1 < m; j++) begin
      win_chars[j] = win_chars[j+1];
    end
    win_chars[m-1] = ch;
    if (chars_to_go > 0) begin
      chars_to_go--;
    end
    if (chars_to_go == 0 && win_fill >= m) begin
      j = m;
      stop = 1'b0;
      while (j > 0 && !stop) begin
        j--;
        c.pos  = pos_plus(win_base, j);
        c.last = 1'b0;
        pending_compares.push_back(c);
        n++;
        if ({1'b0, win_chars[j]} != pattern_byte(j)) begin
          stop = 1'b1;
        end
      end
      pending_compares[pending_compares.size()-1].last = 1'b1;
      last_predicted_pos = pending_compares[pending_compares.size()-1].pos;
      chars_to_go = int'(skip_by[win_chars[m-1]]);
      if (chars_to_go < 1) begin
        chars_to_go = 1;
      end
    end
    if (eot) begin
      restart_search();
    end
    return n;
  endfunction

  task automatic report_mismatch(input string what, input longint unsigned want,
                                 input longint unsigned got);
    $display("MISMATCH at %0t: %s: expected %0d, got %0d", $time, what, want, got);
    error_count++;
  endtask

  // --------------------------------------------------------------------------
  // Request drivers. Text requests come in bursts of random length separated
  // by random gaps unless gap_max is zero; a payload is held until taken.
  // --------------------------------------------------------------------------
  task automatic send_char(input logic [CHAR_BITS-1:0] ch, input logic eot,
                           output int n);
    if (burst_left == 0) begin
      if (gap_max > 0) begin
        text_valid <= 1'b0;
        repeat ($urandom_range(1, gap_max)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    text_valid  <= 1'b1;
    text_char   <= ch;
    end_of_text <= eot;
    @(posedge clk);
    while (text_stall) begin
      @(posedge clk);
    end
    burst_left--;
    items_sent++;
    n = predict_compares(ch, eot);
  endtask

  // A register write; the caller lowers cfg_write after the last one of a
  // group so that back-to-back writes keep the enable high.
  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    apply_write(idx, val);
  endtask

  // Stop sending and let the block drain. A request that caused no result
  // may still sit in the front part, hence the extra settling cycles.
  task automatic drain_block();
    text_valid <= 1'b0;
    while (pending_compares.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    burst_left = 0;
  endtask

  function automatic step_t text_row(input logic [CHAR_BITS-1:0] ch, input logic eot,
                                     input int want_n, input logic [POS_W-1:0] want_last);
    step_t s;
    s = '0;
    s.ch        = ch;
    s.eot       = eot;
    s.want_n    = want_n;
    s.want_last = want_last;
    return s;
  endfunction

  function automatic step_t cfg_row(input logic [CFG_IDX_BITS-1:0] idx,
                                    input logic [CFG_DATA_BITS-1:0] val);
    step_t s;
    s = '0;
    s.is_cfg  = 1'b1;
    s.reg_idx = idx;
    s.data    = val;
    s.want_n  = -1;
    return s;
  endfunction

  // --------------------------------------------------------------------------
  // Result side. The stall pattern switches between modes of its own: no
  // stall at all, light, half and heavy back-pressure.
  // --------------------------------------------------------------------------
  initial begin : stall_pattern
    int run;
    int mode;
    run  = 0;
    mode = 0;
    forever begin
      @(posedge clk);
      if (run == 0) begin
        mode = $urandom_range(0, 3);
        run  = $urandom_range(4, 80);
      end
      run--;
      case (mode)
        0:       result_stall <= 1'b0;
        1:       result_stall <= ($urandom_range(0, 3) == 0);
        2:       result_stall <= ($urandom_range(0, 1) == 0);
        default: result_stall <= ($urandom_range(0, 9) != 0);
      endcase
    end
  end

  // Every accepted result request is matched against the oldest prediction.
  always @(posedge clk) begin : result_check
    compare_t want;
    if (!rst && result_valid && !result_stall) begin
      results_seen++;
      if (pending_compares.size() == 0) begin
        report_mismatch("result with nothing pending, position", 0, compared_position);
      end else begin
        want = pending_compares.pop_front();
        if (compared_position !== want.pos) begin
          report_mismatch("compared_position", want.pos, compared_position);
        end
        if (last_of_run !== want.last) begin
          report_mismatch("last_of_run", want.last, last_of_run);
        end
      end
    end
  end

  // Guard against a hung handshake.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results pending",
               cycle_count, pending_compares.size());
      $display("Some tests failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus: directed table first, then random search phases.
  // --------------------------------------------------------------------------
  initial begin : stimulus
    step_t                    steps [$];
    step_t                    r;
    logic [CFG_IDX_BITS-1:0]  reg_order [3];
    logic [CFG_IDX_BITS-1:0]  rg;
    logic [CHAR_BITS-1:0]     plan_ch [$];
    logic [CFG_DATA_BITS-1:0] val;
    logic [7:0]               b;
    logic                     cfg_busy;
    logic                     eot;
    int n, k, q, sel, rot, target, mutate_at, base, m;
    int random_sent;

    len_reg = LENGTH_BITS'(1);
    pat_lo  = '0;
    pat_hi  = '0;
    for (k = 0; k < PAT_MAX; k++) begin
      win_chars[k] = '0;
    end
    restart_search();
    reg_order[0] = REG_PATTERN_LENGTH;
    reg_order[1] = REG_PATTERN_LOW;
    reg_order[2] = REG_PATTERN_HIGH;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // After reset the pattern is one zero byte, so every character is
    // compared once at its own position; end of text restarts the count.
    steps.push_back(text_row(7'h00, 1'b0, 1, 1));
    steps.push_back(text_row(7'h7F, 1'b0, 1, 2));
    steps.push_back(text_row(7'h55, 1'b1, 1, 3));
    // A length of zero behaves as one; the upper data bits are ignored.
    steps.push_back(cfg_row(REG_PATTERN_LENGTH, 64'hFFFF_FFFF_FFFF_FFE0));
    steps.push_back(text_row(7'h00, 1'b0, 1, 1));
    // Pattern "abac": a mismatch at the first alignment, then a full match
    // on the final character, which also ends the text.
    steps.push_back(cfg_row(REG_PATTERN_LOW, 64'h0000_0000_6361_6261));
    steps.push_back(cfg_row(REG_PATTERN_LENGTH, 64'd4));
    steps.push_back(text_row(7'h78, 1'b0, -1, 0));
    steps.push_back(text_row(7'h61, 1'b0, -1, 0));
    steps.push_back(text_row(7'h62, 1'b0, -1, 0));
    steps.push_back(text_row(7'h61, 1'b0, -1, 0));
    steps.push_back(text_row(7'h63, 1'b1, -1, 0));
    // A length above the maximum acts as sixteen. Byte 0 of the pattern is
    // above 127 and can never match, so the text 0..15 matches fifteen
    // characters and fails on the last, giving the longest possible run.
    steps.push_back(cfg_row(REG_PATTERN_HIGH, 64'h0F0E_0D0C_0B0A_0908));
    steps.push_back(cfg_row(REG_PATTERN_LOW, 64'h0706_0504_0302_0180));
    steps.push_back(cfg_row(REG_PATTERN_LENGTH, 64'hA5A5_0000_0000_001F));
    for (k = 0; k < 15; k++) begin
      steps.push_back(text_row(CHAR_BITS'(k), 1'b0, 0, 0));
    end
    steps.push_back(text_row(7'h0F, 1'b1, PAT_MAX, 1));

    cfg_busy = 1'b0;
    settings_used = 1;
    foreach (steps[i]) begin
      r = steps[i];
      if (r.is_cfg) begin
        if (!cfg_busy) begin
          drain_block();
          settings_used++;
        end
        write_reg(r.reg_idx, r.data);
        cfg_busy = 1'b1;
      end else begin
        if (cfg_busy) begin
          cfg_write <= 1'b0;
          cfg_busy = 1'b0;
        end
        send_char(r.ch, r.eot, n);
        if (r.want_n >= 0) begin
          if (n != r.want_n) begin
            report_mismatch("comparisons for a directed request", r.want_n, n);
          end else if (n > 0 && last_predicted_pos != r.want_last) begin
            report_mismatch("final position of a directed request",
                            r.want_last, last_predicted_pos);
          end
        end
      end
    end

    // Random phases. Each one picks a new setting, then feeds text that is
    // mostly copies of the pattern, some with one character spoilt, mixed
    // with characters of the pattern's alphabet and some plain noise.
    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      drain_block();
      settings_used++;
      gap_max = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      base = $urandom_range(0, 127);
      rot  = $urandom_range(0, 2);
      for (k = 0; k < 3; k++) begin
        rg = reg_order[(k + rot) % 3];
        if (rg == REG_PATTERN_LENGTH) begin
          val = {$urandom, $urandom};
          sel = $urandom_range(0, 9);
          case (sel)
            0:       val[LENGTH_BITS-1:0] = '0;
            1:       val[LENGTH_BITS-1:0] = LENGTH_BITS'(PAT_MAX);
            2:       val[LENGTH_BITS-1:0] = ($urandom_range(0, 1) == 0) ? 5'd31
                                            : LENGTH_BITS'($urandom_range(17, 31));
            3, 4, 5: val[LENGTH_BITS-1:0] = LENGTH_BITS'($urandom_range(1, 4));
            default: val[LENGTH_BITS-1:0] = LENGTH_BITS'($urandom_range(1, 15));
          endcase
          write_reg(rg, val);
        end else if ($urandom_range(0, 3) != 0) begin
          for (q = 0; q < 8; q++) begin
            b = 8'((base + $urandom_range(0, 3)) % 128);
            if ($urandom_range(0, 9) == 0) begin
              b[7] = 1'b1;
            end
            val[8*q +: 8] = b;
          end
          sel = $urandom_range(0, 11);
          if (sel == 0) begin
            val = '0;
          end else if (sel == 1) begin
            val = '1;
          end else if (sel == 2) begin
            val = {$urandom, $urandom};
          end
          write_reg(rg, val);
        end
      end
      cfg_write <= 1'b0;

      m = active_len();
      target = $urandom_range(20, 70);
      if (target > RANDOM_ITEMS - random_sent) begin
        target = RANDOM_ITEMS - random_sent;
      end
      plan_ch.delete();
      while (plan_ch.size() < target) begin
        sel = $urandom_range(0, 9);
        if (sel <= 6) begin
          mutate_at = (sel >= 5) ? $urandom_range(0, m - 1) : -1;
          for (q = 0; q < m; q++) begin
            plan_ch.push_back((q == mutate_at) ? CHAR_BITS'($urandom_range(0, 127))
                                               : pattern_char(q));
          end
        end else if (sel <= 8) begin
          repeat ($urandom_range(1, 3)) plan_ch.push_back(pattern_char($urandom_range(0, m - 1)));
        end else begin
          repeat ($urandom_range(1, 3)) plan_ch.push_back(CHAR_BITS'($urandom_range(0, 127)));
        end
      end
      for (q = 0; q < target; q++) begin
        eot = ($urandom_range(0, 49) == 0) ||
              (q == target - 1 && $urandom_range(0, 1) == 0);
        send_char(plan_ch[q], eot, n);
        random_sent++;
      end
    end

    drain_block();
    $display("Sent %0d text requests under %0d pattern settings.", items_sent, settings_used);
    $display("Checked %0d comparison results; %0d mismatches.", results_seen, error_count);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
